// ===== hdl/gqdp_pkg.sv =====
// ----------------------------------------------------------------------------
// gqdp_pkg: shared types, constants and binary32 helpers
// Item and queue types, configuration indexes, and the staged binary32
// multiply, add and round functions used by the back end.
// ----------------------------------------------------------------------------
package gqdp_pkg;

   localparam logic [3:0]  NIBBLE_MASK = 4'hF;
   localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
   localparam logic [31:0] POS_ZERO    = 32'h0000_0000;
   localparam int          QUEUE_DEPTH = 2;
   localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int          MANT_W      = 50;

   // configuration register indexes
   localparam logic CSR_CODE_WIDTH_MODE     = 1'b0;
   localparam logic CSR_COLUMN_SCALE_ENABLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_ROUND
   } back_state_type;

   typedef enum logic [1:0] {
      OP_GROUP,
      OP_COLUMN,
      OP_ACT,
      OP_ACC
   } op_type;

   // one decoded item as it sits in the queue
   typedef struct packed {
      logic [31:0] activation;
      logic [31:0] code_fp;
      logic [15:0] group_scale;
      logic [15:0] column_scale;
      logic        column_en;
      logic        last_in_row;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type head;
   } queue_head_type;

   // unrounded result: value = mant * 2^(exp - 127 - 48)
   typedef struct packed {
      logic               special;
      logic [31:0]        spec_val;
      logic               sign;
      logic signed [11:0] exp;
      logic [MANT_W-1:0]  mant;
   } op_mid_type;

   // exact conversion of a signed 8-bit code to binary32
   function automatic logic [31:0] code_to_fp(input logic [7:0] code);
      logic        sgn;
      logic [7:0]  mag;
      logic [2:0]  p;
      logic [31:0] tmp;
      sgn = code[7];
      mag = sgn ? 8'(-code) : code;
      p   = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (mag[i]) begin
            p = 3'(i);
         end
      end
      tmp = 32'(mag) << (5'd23 - {2'b00, p});
      if (mag == 8'd0) begin
         return POS_ZERO;
      end
      return {sgn, 8'(8'd127 + {5'b0, p}), tmp[22:0]};
   endfunction

   function automatic logic [31:0] bf16_widen(input logic [15:0] v);
      return {v, 16'h0000};
   endfunction

   // multiply, first half: specials and mantissa product
   function automatic op_mid_type fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
      op_mid_type m;
      logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
      logic [7:0] ea, eb;
      logic [23:0] ma, mb;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      s      = a[31] ^ b[31];
      ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma     = {a[30:23] != 8'd0, a[22:0]};
      mb     = {b[30:23] != 8'd0, b[22:0]};
      m.special  = 1'b0;
      m.spec_val = POS_ZERO;
      m.sign     = s;
      m.exp      = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd127;
      m.mant     = {48'(ma * mb), 2'b00};
      if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
         m.special  = 1'b1;
         m.spec_val = CANON_NAN;
      end else if (a_inf || b_inf) begin
         m.special  = 1'b1;
         m.spec_val = {s, 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
         m.special  = 1'b1;
         m.spec_val = {s, 31'd0};
      end
      return m;
   endfunction

   // add, first half: specials, alignment with sticky, add or subtract
   function automatic op_mid_type fp_add_pre(input logic [31:0] a, input logic [31:0] b);
      op_mid_type        m;
      logic              a_nan, b_nan, a_inf, b_inf, swap;
      logic [31:0]       big, sml;
      logic [7:0]        eb_big, eb_sml, d;
      logic [MANT_W-1:0] mbig, msml, shf, mask;
      logic              stk;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      swap   = (b[30:0] > a[30:0]);
      big    = swap ? b : a;
      sml    = swap ? a : b;
      eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d      = eb_big - eb_sml;
      mbig   = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
      msml   = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
      if (d >= 8'(MANT_W)) begin
         shf = '0;
         stk = (msml != '0);
      end else begin
         mask = (MANT_W'(1) << d) - MANT_W'(1);
         shf  = msml >> d;
         stk  = |(msml & mask);
      end
      shf = shf | MANT_W'(stk);
      m.special  = 1'b0;
      m.spec_val = POS_ZERO;
      m.sign     = big[31];
      m.exp      = $signed({4'b0, eb_big});
      m.mant     = (a[31] == b[31]) ? (mbig + shf) : (mbig - shf);
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
         m.special  = 1'b1;
         m.spec_val = CANON_NAN;
      end else if (a_inf || b_inf) begin
         m.special  = 1'b1;
         m.spec_val = a_inf ? a : b;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         m.special  = 1'b1;
         m.spec_val = {a[31] & b[31], 31'd0};
      end else if (m.mant == '0) begin
         m.special  = 1'b1;
         m.spec_val = POS_ZERO;
      end
      return m;
   endfunction

   // second half: normalize, denormalize if tiny, round to nearest even
   function automatic logic [31:0] fp_round(input op_mid_type m);
      logic [5:0]         lz;
      logic [MANT_W-1:0]  mn, mn2, mask;
      logic signed [11:0] e, sh;
      logic [11:0]        e_use;
      logic               stk, g, st, inc;
      logic [23:0]        m24;
      logic [24:0]        m25;
      logic [7:0]         ef;
      lz = 6'd0;
      for (int i = 0; i < MANT_W; i++) begin
         if (m.mant[i]) begin
            lz = 6'(MANT_W - 1 - i);
         end
      end
      mn    = m.mant << lz;
      e     = m.exp - $signed({6'b0, lz}) + 12'sd1;
      e_use = 12'(e);
      mn2   = mn;
      stk   = 1'b0;
      if (e <= 12'sd0) begin
         sh    = 12'sd1 - e;
         e_use = 12'd1;
         if (sh >= 12'(MANT_W)) begin
            mn2 = '0;
            stk = 1'b1;
         end else begin
            mask = (MANT_W'(1) << sh[5:0]) - MANT_W'(1);
            mn2  = mn >> sh[5:0];
            stk  = |(mn & mask);
         end
      end
      m24 = mn2[MANT_W-1:MANT_W-24];
      g   = mn2[MANT_W-25];
      st  = (|mn2[MANT_W-26:0]) | stk;
      inc = g & (st | m24[0]);
      m25 = {1'b0, m24} + 25'(inc);
      if (m25[24]) begin
         m24   = m25[24:1];
         e_use = e_use + 12'd1;
      end else begin
         m24 = m25[23:0];
      end
      ef = m24[23] ? e_use[7:0] : 8'd0;
      if (m.special) begin
         return m.spec_val;
      end
      if (e_use >= 12'd255) begin
         return {m.sign, 8'hFF, 23'd0};
      end
      return {m.sign, ef, m24[22:0]};
   endfunction

   function automatic logic [31:0] canon_nan(input logic [31:0] v);
      if ((v[30:23] == 8'hFF) && (v[22:0] != 23'd0)) begin
         return CANON_NAN;
      end
      return v;
   endfunction

endpackage

// ===== hdl/gqdp_req_if.sv =====
// ----------------------------------------------------------------------------
// gqdp_req_if: input item channel
// Valid/ready channel carrying one row element.
// ----------------------------------------------------------------------------
interface gqdp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] activation;
   logic [7:0]  weight_byte;
   logic        nibble_select;
   logic [15:0] group_scale;
   logic [15:0] column_scale;
   logic        last_in_row;

   modport source (output valid, activation, weight_byte, nibble_select, group_scale,
                   column_scale, last_in_row, input ready);
   modport sink   (input valid, activation, weight_byte, nibble_select, group_scale,
                   column_scale, last_in_row, output ready);
endinterface

// ===== hdl/gqdp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gqdp_rsp_if: result item channel
// Valid/ready channel carrying one finished row sum.
// ----------------------------------------------------------------------------
interface gqdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_sum;

   modport source (output valid, row_sum, input ready);
   modport sink   (input valid, row_sum, output ready);
endinterface

// ===== hdl/gqdp_front.sv =====
// ----------------------------------------------------------------------------
// gqdp_front: configuration, code decode and item queue
// Holds the mode registers, turns the weight byte into a binary32 code and
// queues decoded items for the back end.
// ----------------------------------------------------------------------------
module gqdp_front
   import gqdp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   gqdp_req_if.sink       req_if,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic           csr_wdata,
   output queue_head_type q_head,
   input  logic           q_pop
);

   logic              mode_ff, mode_in;
   logic              col_en_ff, col_en_in;
   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic [3:0]        nib;
   logic [7:0]        code;
   entry_type         entry;

   assign req_if.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;

   always_comb begin
      nib   = (req_if.nibble_select ? req_if.weight_byte[7:4] : req_if.weight_byte[3:0])
              & NIBBLE_MASK;
      code  = mode_ff ? {{4{nib[3]}}, nib} : req_if.weight_byte;
      entry = '{activation:   req_if.activation,
                code_fp:      code_to_fp(code),
                group_scale:  req_if.group_scale,
                column_scale: req_if.column_scale,
                column_en:    col_en_ff,
                last_in_row:  req_if.last_in_row};
   end

   always_comb begin
      mode_in   = mode_ff;
      col_en_in = col_en_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CODE_WIDTH_MODE:     mode_in   = csr_wdata;
            CSR_COLUMN_SCALE_ENABLE: col_en_in = csr_wdata;
            default:                 mode_in   = mode_ff;
         endcase
      end
      wr_ptr_in = push  ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         col_en_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         col_en_ff <= col_en_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== hdl/gqdp_back.sv =====
// ----------------------------------------------------------------------------
// gqdp_back: binary32 sequencer and accumulator
// Runs each item through a shared two-stage multiply/add unit and keeps the
// row accumulator; finished sums go to an output register.
// ----------------------------------------------------------------------------
module gqdp_back
   import gqdp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type q_head,
   output logic           q_pop,
   output logic           out_valid,
   output logic [31:0]    out_data,
   input  logic           out_ready
);

   back_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   entry_type      item_ff, item_in;
   op_mid_type     mid_ff, mid_in;
   logic [31:0]    w_ff, w_in;
   logic [31:0]    acc_ff, acc_in;
   logic           out_valid_ff, out_valid_in;
   logic [31:0]    out_data_ff, out_data_in;
   logic [31:0]    rnd;

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign rnd       = fp_round(mid_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      mid_in       = mid_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !out_ready;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               item_in  = q_head.head;
               op_in    = OP_GROUP;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            unique case (op_ff)
               OP_GROUP:  mid_in = fp_mul_pre(bf16_widen(item_ff.group_scale), item_ff.code_fp);
               OP_COLUMN: mid_in = fp_mul_pre(w_ff, bf16_widen(item_ff.column_scale));
               OP_ACT:    mid_in = fp_mul_pre(item_ff.activation, w_ff);
               OP_ACC:    mid_in = fp_add_pre(acc_ff, w_ff);
               default:   mid_in = mid_ff;
            endcase
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            unique case (op_ff)
               OP_GROUP: begin
                  w_in     = rnd;
                  op_in    = item_ff.column_en ? OP_COLUMN : OP_ACT;
                  state_in = ST_ISSUE;
               end
               OP_COLUMN: begin
                  w_in     = rnd;
                  op_in    = OP_ACT;
                  state_in = ST_ISSUE;
               end
               OP_ACT: begin
                  w_in     = rnd;
                  op_in    = OP_ACC;
                  state_in = ST_ISSUE;
               end
               OP_ACC: begin
                  if (!item_ff.last_in_row) begin
                     acc_in   = rnd;
                     state_in = ST_IDLE;
                  end else if (!out_valid_ff || out_ready) begin
                     // hold here while the previous sum is still waiting
                     out_valid_in = 1'b1;
                     out_data_in  = canon_nan(rnd);
                     acc_in       = POS_ZERO;
                     state_in     = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_GROUP;
         acc_ff       <= POS_ZERO;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      mid_ff      <= mid_in;
      w_ff        <= w_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ===== hdl/group_quantized_dot_product.sv =====
// ----------------------------------------------------------------------------
// group_quantized_dot_product: int4/int8 group-quantized binary32 dot product
// Streams the elements of one weight row, dequantizes each weight with its
// bf16 group scale (and optional column scale) and accumulates
// activation * weight in binary32, emitting the sum on the row's last item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------------
//   req_if  | in        | valid / ready    | activation, weight_byte,
//           |           |                  | nibble_select, group_scale,
//           |           |                  | column_scale, last_in_row
//   rsp_if  | out       | valid / ready    | row_sum
//   csr_*   | in        | csr_we only      | csr_index, csr_wdata
//
// In the back end an item is first popped from the queue; then the three
// multiplies (two without column scale) and the accumulate each pass, one
// after another, through one shared unpack/align stage followed by one
// normalize/round stage.
// The accumulate of an item needs the previous item's rounded sum.
// A two-entry queue takes items while the back end works; a held result in
// the output register stalls the back end only on the next row end.
// Reset is synchronous: clears modes, queue, accumulator (+0.0) and output.
//
module group_quantized_dot_product
   import gqdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   gqdp_req_if.sink    req_if,
   gqdp_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   queue_head_type q_head;
   logic           q_pop;

   // front: modes, code decode, item queue
   gqdp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   // back: binary32 arithmetic, accumulator, result register
   gqdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_if.row_sum),
      .out_ready (rsp_if.ready)
   );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for group_quantized_dot_product
// Feeds weight rows under every code width / column scale setting, predicts
// each row sum with its own binary32 arithmetic and checks every result in
// order, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------

// one row element as it goes over the request channel
typedef struct {
   logic [31:0] act;
   logic [7:0]  wbyte;
   logic        nsel;
   logic [15:0] gscale;
   logic [15:0] cscale;
   logic        last;
} row_elem_type;

// row sum predictor plus in-order store of sums still due
class row_sum_scoreboard;
   bit          code4;
   bit          col_en;
   bit [31:0]   acc_bits;
   bit [31:0]   sums_due[$];
   int          errors;
   int          sums_checked;
   int          items_seen;

   function new();
      code4        = 1'b0;
      col_en       = 1'b0;
      acc_bits     = 32'h0;
      errors       = 0;
      sums_checked = 0;
      items_seen   = 0;
   endfunction

   // binary32 -> real; exact for every finite value
   function real from_f32(bit [31:0] f);
      bit [23:0] m;
      int        e;
      if (f[30:23] == 8'hFF) begin
         return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
      end
      if (f[30:23] == 8'h00) begin
         if (f[22:0] == 23'd0) begin
            return $bitstoreal({f[31], 63'd0});
         end
         m = {1'b0, f[22:0]};
         e = -126;
         while (!m[23]) begin
            m = m << 1;
            e--;
         end
      end else begin
         m = {1'b1, f[22:0]};
         e = int'(f[30:23]) - 127;
      end
      return $bitstoreal({f[31], 11'(e + 1023), m[22:0], 29'd0});
   endfunction

   // real -> binary32, nearest even, subnormals kept. The real holds the
   // exact product or a once-rounded sum with 53 bits, wide enough that
   // this second rounding gives the correctly rounded binary32 result.
   function bit [31:0] to_f32(real r);
      bit [63:0] b;
      bit [63:0] mm;
      bit [63:0] q;
      bit [24:0] keep;
      bit        s, g, st;
      int        e, n;
      b  = $realtobits(r);
      s  = b[63];
      e  = int'(b[62:52]);
      mm = {11'd0, 1'b1, b[51:0]};
      if (e == 2047) begin
         return (b[51:0] != 0) ? gqdp_pkg::CANON_NAN : {s, 8'hFF, 23'd0};
      end
      if (e == 0) begin
         return {s, 31'd0};
      end
      e = e - 1023;
      if (e >= -126) begin
         keep = {1'b0, mm[52:29]};
         g    = mm[28];
         st   = |mm[27:0];
         keep = keep + 25'(g & (st | keep[0]));
         if (keep[24]) begin
            keep = keep >> 1;
            e++;
         end
         if (e > 127) begin
            return {s, 8'hFF, 23'd0};
         end
         return {s, 8'(e + 127), keep[22:0]};
      end
      // subnormal: count in units of 2^-149
      n = -97 - e;
      if (n > 54) begin
         return {s, 31'd0};
      end
      q  = mm >> n;
      g  = mm[n - 1];
      st = (mm & ((64'd1 << (n - 1)) - 64'd1)) != 0;
      q  = q + 64'(g & (st | q[0]));
      return {s, q[30:0]};
   endfunction

   function void set_reg(logic idx, bit v);
      if (idx == gqdp_pkg::CSR_CODE_WIDTH_MODE) begin
         code4 = v;
      end else begin
         col_en = v;
      end
   endfunction

   function void note_item(row_elem_type it);
      int        code;
      bit [3:0]  nib;
      bit [31:0] wt, prod;
      items_seen++;
      if (code4) begin
         nib  = (it.nsel ? it.wbyte[7:4] : it.wbyte[3:0]) & gqdp_pkg::NIBBLE_MASK;
         code = int'($signed(nib));
      end else begin
         code = int'($signed(it.wbyte));
      end
      wt = to_f32(from_f32({it.gscale, 16'h0}) * real'(code));
      if (col_en) begin
         wt = to_f32(from_f32(wt) * from_f32({it.cscale, 16'h0}));
      end
      prod     = to_f32(from_f32(it.act) * from_f32(wt));
      acc_bits = to_f32(from_f32(acc_bits) + from_f32(prod));
      if (it.last) begin
         sums_due.push_back(acc_bits);
         acc_bits = 32'h0;
      end
   endfunction

   function void check_sum(bit [31:0] got);
      bit [31:0] want;
      if (sums_due.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("unexpected row_sum %08h", got);
         end
         return;
      end
      want = sums_due.pop_front();
      sums_checked++;
      if (got !== want) begin
         errors++;
         if (errors <= 10) begin
            $display("row_sum mismatch: expected %08h actual %08h", want, got);
         end
      end
   endfunction
endclass

module tb_top
   import gqdp_pkg::*;
();

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic csr_wdata;

   gqdp_req_if req();
   gqdp_rsp_if rsp();

   group_quantized_dot_product DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   row_sum_scoreboard sums = new();

   bit no_idle;        // burst stretch: neither side idles
   bit hold_rsp;       // asks the receiver for one long stall
   int settings_run;

   initial begin
      clock = 1'b0;
   end
   always #1 clock = ~clock;

   // hard stop well past the slowest legal run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // sample both channels on the edge where the handshake lands
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         sums.note_item('{req.activation, req.weight_byte, req.nibble_select,
                          req.group_scale, req.column_scale, req.last_in_row});
      end
      if (!reset && rsp.valid && rsp.ready) begin
         sums.check_sum(rsp.row_sum);
      end
   end

   // receiver: random stalls, a burst stretch, and one long hold-off on request
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp.ready <= no_idle || ($urandom_range(99) >= 34);
         end
      end
   end

   // binary32 pattern: mostly moderate values, some raw bits and specials
   function automatic logic [31:0] rand_f32();
      logic [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                    32'hFF80_0000, 32'h7FC0_0000, 32'hFF81_2345,
                                    32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                                    32'h0080_0000};
      case ($urandom_range(9))
         6, 7: return $urandom;
         8: return specials[$urandom_range(9)];
         9: return {1'($urandom), ($urandom_range(1) ? 8'($urandom_range(3))
                                                     : 8'($urandom_range(251, 254))),
                    23'($urandom)};
         default: return {1'($urandom), 8'($urandom_range(107, 147)), 23'($urandom)};
      endcase
   endfunction

   function automatic logic [15:0] rand_bf16();
      logic [31:0] f;
      if ($urandom_range(9) < 7) begin
         return {1'($urandom), 8'($urandom_range(121, 133)), 7'($urandom)};
      end
      f = rand_f32();
      return f[31:16];
   endfunction

   // offer one item and hold it until taken; valid stays high for the next unless a random idle follows
   task automatic send_elem(row_elem_type it);
      req.valid         <= 1'b1;
      req.activation    <= it.act;
      req.weight_byte   <= it.wbyte;
      req.nibble_select <= it.nsel;
      req.group_scale   <= it.gscale;
      req.column_scale  <= it.cscale;
      req.last_in_row   <= it.last;
      do begin
         @(posedge clock);
      end while (!req.ready);
      if (!no_idle && $urandom_range(99) < 34) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_fields(logic [31:0] a, logic [7:0] w, logic ns,
                              logic [15:0] g, logic [15:0] c, logic l);
      send_elem('{a, w, ns, g, c, l});
   endtask

   // random rows, mostly short, now and then a long one
   task automatic send_rows(int n_items, int burst_from, int burst_to);
      row_elem_type it;
      int           sent, len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            no_idle   = (sent >= burst_from) && (sent < burst_to);
            it.act    = rand_f32();
            it.wbyte  = 8'($urandom);
            it.nsel   = 1'($urandom);
            it.gscale = rand_bf16();
            it.cscale = rand_bf16();
            it.last   = (k == len - 1);
            send_elem(it);
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   // wait for all sums, let the back end drain, then write both registers
   task automatic set_modes(bit code4, bit col_en);
      req.valid <= 1'b0;
      while (sums.sums_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CODE_WIDTH_MODE;
      csr_wdata <= code4;
      @(posedge clock);
      sums.set_reg(CSR_CODE_WIDTH_MODE, code4);
      csr_index <= CSR_COLUMN_SCALE_ENABLE;
      csr_wdata <= col_en;
      @(posedge clock);
      sums.set_reg(CSR_COLUMN_SCALE_ENABLE, col_en);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   initial begin
      int wait_cycles;
      no_idle               = 1'b0;
      hold_rsp              = 1'b0;
      settings_run          = 0;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_CODE_WIDTH_MODE;
      csr_wdata            <= 1'b0;
      req.valid            <= 1'b0;
      req.activation       <= '0;
      req.weight_byte      <= '0;
      req.nibble_select    <= 1'b0;
      req.group_scale      <= '0;
      req.column_scale     <= '0;
      req.last_in_row      <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset modes: 8-bit codes, no column scale; nibble select is ignored
      send_fields(32'h3F80_0000, 8'h7F, 1'b1, 16'h3F80, 16'hFFFF, 1'b1);
      send_fields(32'hBF80_0000, 8'h80, 1'b0, 16'h3F80, 16'h0000, 1'b0);
      send_fields(32'h3F80_0000, 8'h80, 1'b1, 16'hBF80, 16'h0000, 1'b1);
      // exact cancellation to +0, then a negative-zero-only row
      send_fields(32'h4000_0000, 8'h01, 1'b0, 16'h3F80, 16'h0000, 1'b0);
      send_fields(32'hC000_0000, 8'h01, 1'b0, 16'h3F80, 16'h0000, 1'b1);
      send_fields(32'h8000_0000, 8'h05, 1'b0, 16'h3F80, 16'h0000, 1'b1);
      // NaN sources: NaN activation, inf times zero code, opposite infinities
      send_fields(32'hFF81_2345, 8'h03, 1'b0, 16'h3F80, 16'h0000, 1'b1);
      send_fields(32'h7F80_0000, 8'h00, 1'b0, 16'h3F80, 16'h0000, 1'b1);
      send_fields(32'h7F80_0000, 8'h01, 1'b0, 16'h3F80, 16'h0000, 1'b0);
      send_fields(32'hFF80_0000, 8'h01, 1'b0, 16'h3F80, 16'h0000, 1'b1);
      // overflow to inf, subnormal scale and activation, NaN scale
      send_fields(32'h7F7F_FFFF, 8'h7F, 1'b0, 16'h7F7F, 16'h0000, 1'b1);
      send_fields(32'h0000_0001, 8'hFF, 1'b0, 16'h0001, 16'h0000, 1'b1);
      send_fields(32'h3F80_0000, 8'h02, 1'b0, 16'h7FC1, 16'h0000, 1'b1);
      send_fields(32'hFFFF_FFFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);

      // 4-bit codes: both nibbles, both sign extremes
      set_modes(1'b1, 1'b0);
      send_fields(32'h3F80_0000, 8'h8F, 1'b0, 16'h3F80, 16'h4000, 1'b0);
      send_fields(32'h3F80_0000, 8'h8F, 1'b1, 16'h3F80, 16'h4000, 1'b1);
      send_fields(32'h3F80_0000, 8'h78, 1'b0, 16'h3F80, 16'h0000, 1'b0);
      send_fields(32'h3F80_0000, 8'h78, 1'b1, 16'h3F80, 16'h0000, 1'b1);

      // column scale on, both code widths
      set_modes(1'b0, 1'b1);
      send_fields(32'h3F80_0000, 8'h7F, 1'b0, 16'h4000, 16'hC040, 1'b1);
      send_fields(32'h3F80_0000, 8'h01, 1'b0, 16'h3F80, 16'h7F80, 1'b0);
      send_fields(32'h3F80_0000, 8'h01, 1'b0, 16'h3F80, 16'h0000, 1'b1);
      set_modes(1'b1, 1'b1);
      send_fields(32'h4040_0000, 8'h9E, 1'b1, 16'h3F00, 16'h0001, 1'b1);

      // random part, one block per setting
      set_modes(1'b0, 1'b0);
      send_rows(380, 100, 250);
      set_modes(1'b1, 1'b0);
      hold_rsp = 1'b1;          // block fills up and pushes back on the input
      send_rows(380, -1, -1);
      set_modes(1'b0, 1'b1);
      send_rows(380, -1, -1);
      set_modes(1'b1, 1'b1);
      send_rows(380, 200, 300);
      req.valid <= 1'b0;

      while (sums.sums_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);

      $display("ran %0d items, checked %0d row sums over %0d register settings",
               sums.items_seen, sums.sums_checked, settings_run + 1);
      $display("covered 8/4-bit codes, column scale on/off, specials and a long result stall");
      if (sums.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors", sums.errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/gqdp_pkg.sv
hdl/gqdp_req_if.sv
hdl/gqdp_rsp_if.sv
hdl/gqdp_front.sv
hdl/gqdp_back.sv
hdl/group_quantized_dot_product.sv
bench/tb_top.sv
